>>> sv/b64_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the sextet-to-ASCII mapping for the Base64 encoder.
// No dependencies.
package b64_pkg;

   // ASCII anchors of the Base64 alphabet
   localparam logic [6:0] CHAR_UPPER_A = 7'd65;
   localparam logic [6:0] CHAR_LOWER_A = 7'd97;
   localparam logic [6:0] CHAR_DIGIT_0 = 7'd48;
   localparam logic [6:0] CHAR_PLUS    = 7'h2B;
   localparam logic [6:0] CHAR_SLASH   = 7'h2F;
   localparam logic [6:0] CHAR_PAD     = 7'h3D;

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

   // Byte position within a three-byte group
   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_SECOND = 2'd1,
      PH_THIRD  = 2'd2
   } phase_type;

   // One classified input byte: two sextets, then pads up to the count
   typedef struct packed {
      logic [5:0] sextet0;
      logic [5:0] sextet1;
      logic [1:0] count_m1;  // characters in the job minus one
      logic       final_msg; // job closes the message
   } job_type;

   // Queue handshake between front and back
   typedef struct packed {
      logic    push;
      job_type job;
   } push_type;

   typedef struct packed {
      logic    empty;
      logic    full;
      job_type head;
   } queue_stat_type;

   function automatic logic [6:0] sextet_to_char(input logic [5:0] v);
      logic [6:0] v7;
      v7 = {1'b0, v};
      if (v < 6'd26)      return 7'(CHAR_UPPER_A + v7);
      else if (v < 6'd52) return 7'(CHAR_LOWER_A + v7 - 7'd26);
      else if (v < 6'd62) return 7'(CHAR_DIGIT_0 + v7 - 7'd52);
      else if (v == 6'd62) return CHAR_PLUS;
      else                return CHAR_SLASH;
   endfunction

endpackage

>>> sv/base64_stream_encoder.sv
`timescale 1ns / 1ps
// Base64 stream encoder: one byte in per item, one ASCII character out per item.
// The first character of a byte passes through the job queue and then the output register
// before it is valid on the result port. Throughput: one character per cycle on the result
// port while the receiver is ready; a byte yields 1 or 2 characters, up to 4 for a final byte;
// the two-entry job queue takes a byte every cycle until it fills, then input follows
// the characters, three bytes per four characters in a long message.
// Reset: synchronous, clears phase, carry, queue and output valid.
module base64_stream_encoder import b64_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // final_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [6:0] code_char, [7] zero
   output logic       rsp_tlast    // last_char
);

   push_type            q_push;
   queue_stat_type      q_stat;
   logic                pop;
   logic [QLVL_W-1:0]   level;
   phase_type           phase;

   b64_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_stat.full),
      .q_push     (q_push),
      .phase      (phase)
   );

   b64_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .pop    (pop),
      .q_stat (q_stat),
      .level  (level)
   );

   b64_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // A final byte always returns the group to its first position
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> (phase == PH_FIRST))
      else $error("phase not cleared after final byte");

   // Queue never overfills
   assert property (@(posedge clock) disable iff (reset)
      level <= QLVL_W'(QUEUE_DEPTH))
      else $error("job queue level out of range");

   // A pad character that is not the message's closing character is followed by another pad
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tdata[6:0] == CHAR_PAD && !rsp_tlast)
      |=> (rsp_tvalid && rsp_tdata[6:0] == CHAR_PAD))
      else $error("pad character not followed by pad");

   // Input is refused only while the queue is full
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (level == QLVL_W'(QUEUE_DEPTH)))
      else $error("input stalled with room in queue");

endmodule

>>> sv/b64_front.sv
`timescale 1ns / 1ps
// Front end: accepts bytes, tracks group phase and carry bits, builds one job per byte.
// Depends on b64_pkg.
module b64_front import b64_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [7:0]     req_tdata,   // [7:0] data_byte
   input  logic           req_tlast,   // final_byte
   input  logic           q_full,
   output push_type       q_push,
   output phase_type      phase
);

   phase_type  phase_ff, phase_in;
   logic [3:0] carry_ff, carry_in;
   logic       accept;
   job_type    job;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign phase      = phase_ff;

   // Advance the group phase on each accepted item; a final byte closes the group
   always_comb begin
      phase_in = phase_ff;
      carry_in = carry_ff;
      if (accept) begin
         if (req_tlast) begin
            phase_in = PH_FIRST;
            carry_in = 4'd0;
         end else begin
            case (phase_ff)
               PH_SECOND: begin
                  phase_in = PH_THIRD;
                  carry_in = req_tdata[3:0];
               end
               PH_THIRD: begin
                  phase_in = PH_FIRST;
                  carry_in = 4'd0;
               end
               default: begin
                  phase_in = PH_SECOND;
                  carry_in = {2'b00, req_tdata[1:0]};
               end
            endcase
         end
      end
   end

   // Split the byte into sextets and set the character count
   always_comb begin
      job.final_msg = req_tlast;
      case (phase_ff)
         PH_SECOND: begin
            job.sextet0  = {carry_ff[1:0], req_tdata[7:4]};
            job.sextet1  = {req_tdata[3:0], 2'b00};
            job.count_m1 = req_tlast ? 2'd2 : 2'd0;
         end
         PH_THIRD: begin
            job.sextet0  = {carry_ff, req_tdata[7:6]};
            job.sextet1  = req_tdata[5:0];
            job.count_m1 = 2'd1;
         end
         default: begin
            job.sextet0  = req_tdata[7:2];
            job.sextet1  = {req_tdata[1:0], 4'b0000};
            job.count_m1 = req_tlast ? 2'd3 : 2'd0;
         end
      endcase
   end

   assign q_push.push = accept;
   assign q_push.job  = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         carry_ff <= 4'd0;
      end else begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

endmodule

>>> sv/b64_queue.sv
`timescale 1ns / 1ps
// Two-entry job queue that decouples the front end from the character emitter.
// Depends on b64_pkg.
module b64_queue import b64_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  push_type            q_push,
   input  logic                pop,
   output queue_stat_type      q_stat,
   output logic [QLVL_W-1:0]   level
);

   job_type             mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QLVL_W-1:0]   level_ff, level_in;
   logic                do_push, do_pop;

   assign do_push = q_push.push && (level_ff != QLVL_W'(QUEUE_DEPTH));
   assign do_pop  = pop && (level_ff != '0);

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         level_in = QLVL_W'(level_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         level_in = QLVL_W'(level_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= q_push.job;
      end
   end

   assign q_stat.empty = (level_ff == '0);
   assign q_stat.full  = (level_ff == QLVL_W'(QUEUE_DEPTH));
   assign q_stat.head  = mem[rd_ptr_ff];
   assign level        = level_ff;

endmodule

>>> sv/b64_back.sv
`timescale 1ns / 1ps
// Back end: walks the head job one character per cycle, while the output is not stalled, into the output register.
// Depends on b64_pkg.
module b64_back import b64_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  queue_stat_type  q_stat,
   output logic            pop,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [7:0]      rsp_tdata,   // [6:0] code_char, [7] zero
   output logic            rsp_tlast    // last_char
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [6:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       load, job_done;

   // Load a new character when the output register is free or being drained
   assign load     = !q_stat.empty && (!valid_ff || rsp_tready);
   assign job_done = (idx_ff == q_stat.head.count_m1);
   assign pop      = load && job_done;

   // Select the character at the current index
   always_comb begin
      case (idx_ff)
         2'd0:    char_in = sextet_to_char(q_stat.head.sextet0);
         2'd1:    char_in = sextet_to_char(q_stat.head.sextet1);
         default: char_in = CHAR_PAD;
      endcase
      last_in = q_stat.head.final_msg && job_done;
   end

   // Step the index, hold the output while stalled
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = job_done ? 2'd0 : 2'(idx_ff + 1'b1);
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= char_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, char_ff};
   assign rsp_tlast  = last_ff;

endmodule

>>> tb/base64_stream_encoder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for base64_stream_encoder: random-paced byte stream in,
// Base64 characters checked against an in-bench encoder. Depends on b64_pkg.
module base64_stream_encoder_tb;
   import b64_pkg::*;

   localparam int QUIET_LIMIT   = 2000;
   localparam int RANDOM_BYTES  = 86;
   localparam int SETTLE_CYCLES = 10;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } byte_item_type;

   typedef struct packed {
      logic [6:0] code_char;
      logic       last_char;
   } char_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] data_byte
   logic       req_tlast = 1'b0;    // final_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [6:0] code_char, [7] zero
   logic       rsp_tlast;           // last_char

   byte_item_type pending_bytes[$];
   char_item_type expected_chars[$];

   // Encoder state tracked alongside the block
   phase_type  enc_phase = PH_FIRST;
   logic [3:0] enc_carry = 4'd0;

   int bytes_sent   = 0;
   int chars_taken  = 0;
   int error_count  = 0;
   int quiet_cycles = 0;
   int hold_count   = 0;
   bit hold_done    = 1'b0;

   base64_stream_encoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Map a six-bit group onto the Base64 alphabet
   function automatic logic [6:0] alphabet_char(input logic [5:0] sextet);
      logic [6:0] s7;
      s7 = {1'b0, sextet};
      if (sextet < 6'd26)       return 7'(CHAR_UPPER_A + s7);
      else if (sextet < 6'd52)  return 7'(CHAR_LOWER_A + (s7 - 7'd26));
      else if (sextet < 6'd62)  return 7'(CHAR_DIGIT_0 + (s7 - 7'd52));
      else if (sextet == 6'd62) return CHAR_PLUS;
      else                      return CHAR_SLASH;
   endfunction

   task automatic queue_char(input logic [6:0] ch, input logic last);
      char_item_type c;
      c.code_char = ch;
      c.last_char = last;
      expected_chars.push_back(c);
   endtask

   // Encode one accepted byte: queue its characters and advance the group phase
   task automatic encode_byte(input logic [7:0] b, input logic fin);
      case (enc_phase)
         PH_SECOND: begin
            queue_char(alphabet_char({enc_carry[1:0], b[7:4]}), 1'b0);
            if (fin) begin
               queue_char(alphabet_char({b[3:0], 2'b00}), 1'b0);
               queue_char(CHAR_PAD, 1'b1);
               enc_carry = 4'd0;
               enc_phase = PH_FIRST;
            end else begin
               enc_carry = b[3:0];
               enc_phase = PH_THIRD;
            end
         end
         PH_THIRD: begin
            queue_char(alphabet_char({enc_carry, b[7:6]}), 1'b0);
            queue_char(alphabet_char(b[5:0]), fin);
            enc_carry = 4'd0;
            enc_phase = PH_FIRST;
         end
         default: begin
            // an unused phase code behaves like the first byte of a group
            queue_char(alphabet_char(b[7:2]), 1'b0);
            if (fin) begin
               queue_char(alphabet_char({b[1:0], 4'b0000}), 1'b0);
               queue_char(CHAR_PAD, 1'b0);
               queue_char(CHAR_PAD, 1'b1);
               enc_carry = 4'd0;
               enc_phase = PH_FIRST;
            end else begin
               enc_carry = {2'b00, b[1:0]};
               enc_phase = PH_SECOND;
            end
         end
      endcase
   endtask

   // Driver: hold an item until accepted, then pull the next one or idle
   always @(posedge clock) begin
      byte_item_type next_byte;
      logic          go_idle;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) bytes_sent = bytes_sent + 1;
         go_idle = !(bytes_sent >= 40 && bytes_sent < 75) && ($urandom_range(99) < 27);
         if (pending_bytes.size() > 0 && !go_idle) begin
            next_byte = pending_bytes.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_byte.data_byte;
            req_tlast  <= next_byte.final_byte;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, one long hold-off, one stretch always ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) chars_taken = chars_taken + 1;
         if (hold_count > 0) begin
            hold_count = hold_count - 1;
            rsp_tready <= 1'b0;
         end else if (chars_taken >= 70 && !hold_done) begin
            hold_done  = 1'b1;
            hold_count = 60;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (chars_taken >= 100 && chars_taken < 170) ||
                          ($urandom_range(99) >= 27);
         end
      end
   end

   // Monitor: predict on each accepted byte, check each accepted character
   always @(posedge clock) begin
      char_item_type want;
      if (reset) begin
         enc_phase = PH_FIRST;
         enc_carry = 4'd0;
      end else begin
         if (req_tvalid && req_tready) encode_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected character: tdata %h tlast %b", rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_tdata[6:0] !== want.code_char) begin
                  $error("code_char: expected %h actual %h", want.code_char, rsp_tdata[6:0]);
                  error_count++;
               end
               if (rsp_tlast !== want.last_char) begin
                  $error("last_char: expected %b actual %b", want.last_char, rsp_tlast);
                  error_count++;
               end
               if (rsp_tdata[7] !== 1'b0) begin
                  $error("tdata fill bit: expected 0 actual %b", rsp_tdata[7]);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic add_byte(input logic [7:0] b, input logic fin);
      byte_item_type item;
      item.data_byte  = b;
      item.final_byte = fin;
      pending_bytes.push_back(item);
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() > 0 || req_tvalid || expected_chars.size() > 0)
         @(negedge clock);
   endtask

   // Random messages, mostly short, some long; bytes lean toward the extremes
   task automatic add_random_messages(input int n_bytes);
      int queued;
      int msg_len;
      logic [7:0] b;
      queued = 0;
      while (queued < n_bytes) begin
         msg_len = ($urandom_range(9) == 0) ? $urandom_range(30, 10) : $urandom_range(9, 1);
         for (int i = 0; i < msg_len; i++) begin
            case ($urandom_range(6))
               0:       b = 8'h00;
               1:       b = 8'hFF;
               default: b = 8'($urandom());
            endcase
            add_byte(b, i == msg_len - 1);
         end
         queued += msg_len;
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single-byte messages: two pads, all-zero and all-one
      add_byte(8'h00, 1'b1);
      add_byte(8'hFF, 1'b1);
      // two bytes: one pad
      add_byte(8'h4D, 1'b0);
      add_byte(8'h61, 1'b1);
      // full groups, no pad: all '+' then all '/'
      add_byte(8'hFB, 1'b0);
      add_byte(8'hEF, 1'b0);
      add_byte(8'hBE, 1'b1);
      add_byte(8'hFF, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'hFF, 1'b1);
      // final byte opening a new group after a full one
      add_byte(8'h00, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'h01, 1'b1);
      // five bytes across groups, letters and one pad
      add_byte(8'h4D, 1'b0);
      add_byte(8'h61, 1'b0);
      add_byte(8'h6E, 1'b0);
      add_byte(8'h79, 1'b0);
      add_byte(8'h20, 1'b1);
      // alternating bit patterns
      add_byte(8'h80, 1'b0);
      add_byte(8'h7F, 1'b0);
      add_byte(8'hAA, 1'b0);
      add_byte(8'h55, 1'b1);

      // sender pauses until every character is out
      wait_drained();

      add_random_messages(RANDOM_BYTES / 2);
      wait_drained();
      add_random_messages(RANDOM_BYTES - RANDOM_BYTES / 2);
      wait_drained();

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
